// ===== rtl/core/bcedit_pkg.sv =====
// Shared types, constants and helper functions for the barcode one-edit
// neighbor generator. Used by every module in rtl/core; depends on nothing.
package bcedit_pkg;

  // Largest barcode the datapath holds, in bases, and the derived widths.
  localparam int MaxBases = 20;
  localparam int BarcodeW = 2 * MaxBases;
  localparam int LenW     = 5;
  localparam int ShiftW   = LenW + 1;

  // Reset value of the expected_length register.
  localparam logic [LenW-1:0] ExpectedLengthReset = 5'd16;

  // Result slots of one item: three substitutions, then four
  // insertion/deletion pairs.
  localparam int SlotW = 4;
  localparam logic [SlotW-1:0] SubSlots     = 4'd3;
  localparam logic [SlotW-1:0] LastSubSlot  = 4'd2;
  localparam logic [SlotW-1:0] LastSlot     = 4'd10;

  // Two-bit base encoding.
  localparam logic [1:0] BaseA = 2'd0;
  localparam logic [1:0] BaseC = 2'd1;
  localparam logic [1:0] BaseG = 2'd2;
  localparam logic [1:0] BaseT = 2'd3;

  typedef enum logic [1:0] {
    EDIT_SUB = 2'd0,
    EDIT_INS = 2'd1,
    EDIT_DEL = 2'd2
  } edit_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_BAD_POS  = 2'd2
  } status_t;

  // One accepted item, already checked and with stray bits cleared.
  typedef struct packed {
    logic [BarcodeW-1:0] barcode;
    logic [LenW-1:0]     length;
    logic [LenW-1:0]     position;
    status_t             status;
  } item_t;

  // One result as it leaves the edit logic.
  typedef struct packed {
    logic [BarcodeW-1:0] neighbor;
    edit_kind_t          kind;
    logic [1:0]          base;
    status_t             status;
    logic                last;
  } result_t;

  // Mask covering the low n bases.
  function automatic logic [BarcodeW-1:0] base_mask(input logic [LenW-1:0] n);
    logic [BarcodeW-1:0] m;
    if (n >= LenW'(MaxBases)) begin
      m = '1;
    end else begin
      m = (BarcodeW'(1) << {n, 1'b0}) - BarcodeW'(1);
    end
    return m;
  endfunction

  // Bases are visited in the order A, T, C, G.
  function automatic logic [1:0] order_base(input logic [1:0] idx);
    logic [1:0] b;
    case (idx)
      2'd0:    b = BaseA;
      2'd1:    b = BaseT;
      2'd2:    b = BaseC;
      default: b = BaseG;
    endcase
    return b;
  endfunction

  // Place of a base in the visiting order.
  function automatic logic [1:0] order_index(input logic [1:0] b);
    logic [1:0] idx;
    case (b)
      BaseA:   idx = 2'd0;
      BaseT:   idx = 2'd1;
      BaseC:   idx = 2'd2;
      default: idx = 2'd3;
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/core/bcedit_edit.sv =====
// Combinational edit logic: builds the result for one slot of a stored item.
// Depends on bcedit_pkg.
module bcedit_edit (
  input  bcedit_pkg::item_t                 item,
  input  logic [bcedit_pkg::SlotW-1:0]      slot,
  output bcedit_pkg::result_t               res
);

  always_comb begin
    logic [bcedit_pkg::ShiftW-1:0]   sh;
    logic [bcedit_pkg::ShiftW-1:0]   sh_end;
    logic [bcedit_pkg::LenW-1:0]     len_m1;
    logic [bcedit_pkg::BarcodeW-1:0] x;
    logic [bcedit_pkg::BarcodeW-1:0] lowm;
    logic [bcedit_pkg::BarcodeW-1:0] low;
    logic [bcedit_pkg::BarcodeW-1:0] ins;
    logic [bcedit_pkg::BarcodeW-1:0] del;
    logic [bcedit_pkg::BarcodeW-1:0] sub;
    logic [1:0]                      cur;
    logic [1:0]                      cur_idx;
    logic [1:0]                      j;
    logic [1:0]                      b;
    logic [bcedit_pkg::SlotW-1:0]    t;
    logic                            at_end;

    x       = item.barcode;
    sh      = {item.position, 1'b0};
    len_m1  = item.length - bcedit_pkg::LenW'(1);
    sh_end  = {len_m1, 1'b0};
    cur     = 2'(x >> sh);
    cur_idx = bcedit_pkg::order_index(cur);
    t       = slot - bcedit_pkg::SubSlots;
    at_end  = (item.position == len_m1);

    // Substitution slots skip the base already present.
    if (slot < bcedit_pkg::SubSlots) begin
      j = (slot[1:0] < cur_idx) ? slot[1:0] : slot[1:0] + 2'd1;
    end else begin
      j = t[2:1];
    end
    b = bcedit_pkg::order_base(j);

    lowm = bcedit_pkg::base_mask(item.position);
    low  = x & lowm;
    sub  = (x & ~(bcedit_pkg::BarcodeW'(3) << sh)) | (bcedit_pkg::BarcodeW'(b) << sh);
    ins  = (low | ((x & ~lowm) << 2) | (bcedit_pkg::BarcodeW'(b) << sh))
           & bcedit_pkg::base_mask(item.length);
    del  = ((low | ((x >> 2) & ~lowm)) & bcedit_pkg::base_mask(len_m1))
           | (bcedit_pkg::BarcodeW'(b) << sh_end);

    if (item.status != bcedit_pkg::STATUS_OK) begin
      res.neighbor = '0;
      res.kind     = bcedit_pkg::EDIT_SUB;
      res.base     = bcedit_pkg::BaseA;
      res.status   = item.status;
      res.last     = 1'b1;
    end else if (slot < bcedit_pkg::SubSlots) begin
      res.neighbor = sub;
      res.kind     = bcedit_pkg::EDIT_SUB;
      res.base     = b;
      res.status   = bcedit_pkg::STATUS_OK;
      res.last     = at_end && (slot == bcedit_pkg::LastSubSlot);
    end else begin
      res.neighbor = t[0] ? del : ins;
      res.kind     = t[0] ? bcedit_pkg::EDIT_DEL : bcedit_pkg::EDIT_INS;
      res.base     = b;
      res.status   = bcedit_pkg::STATUS_OK;
      res.last     = (slot == bcedit_pkg::LastSlot);
    end
  end

endmodule

// ===== rtl/core/barcode_one_edit_neighbors.sv =====
// Top level of the barcode one-edit neighbor generator.
// Depends on bcedit_pkg and bcedit_edit.
//
// Usage. The host presents a packed barcode (two bits per base, base 0 in
// bits 1:0), its length and one base position, and raises start. The item
// transfers at a rising edge where start is high and busy is low. The block
// then emits the length-preserving one-edit neighbors of that position, one
// result per cycle on neighbor/edit_kind/edit_base/status/last, each marked
// by a one-cycle result_strobe; last flags the final result of the item.
// The receiver cannot stall: every strobed result transfers at the edge that
// ends its cycle.
//
// Timing. The item register and then the result register lie between the
// transfer and the ports. An item produces eleven results (three
// substitutions, then an insertion and a deletion per base), three when the
// position is the last base, and one when it is rejected, at one per cycle;
// no new item is taken before the previous one reaches its final slot. busy
// falls in the cycle of the final slot, so the next item transfers at the
// edge that registers the previous item's last result.
//
// Configuration. expected_length is written through cfg_valid/cfg_ready/
// cfg_data, always ready, and is meant to change only while the block is
// idle. Reset (synchronous, active high) sets it to 16, drops any item in
// flight and clears the result strobe.
module barcode_one_edit_neighbors (
  input  logic                            clk,
  input  logic                            rst,
  // Item channel.
  input  logic                            start,
  output logic                            busy,
  input  logic [bcedit_pkg::BarcodeW-1:0] barcode,
  input  logic [bcedit_pkg::LenW-1:0]     length,
  input  logic [bcedit_pkg::LenW-1:0]     position,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bcedit_pkg::LenW-1:0]     cfg_data,
  // Result channel.
  output logic                            result_strobe,
  output logic [bcedit_pkg::BarcodeW-1:0] neighbor,
  output logic [1:0]                      edit_kind,
  output logic [1:0]                      edit_base,
  output logic [1:0]                      status,
  output logic                            last
);

  logic [bcedit_pkg::LenW-1:0]  expected_length;
  logic                         loaded;
  logic [bcedit_pkg::SlotW-1:0] slot;
  bcedit_pkg::item_t            item;
  bcedit_pkg::item_t            item_next;
  bcedit_pkg::result_t          res;
  logic                         accept;

  // The configuration register never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= bcedit_pkg::ExpectedLengthReset;
    end else if (cfg_valid && cfg_ready) begin
      expected_length <= cfg_data;
    end
  end

  // The block is busy while the stored item still has slots after the
  // current one; the final slot frees the input register.
  assign busy   = loaded && !res.last;
  assign accept = start && !busy;

  // Check the item on the way in and clear bases beyond its length, so the
  // edit logic only ever sees a clean barcode and a settled status. The
  // length check takes priority over the position check.
  always_comb begin
    item_next.barcode  = barcode & bcedit_pkg::base_mask(length);
    item_next.length   = length;
    item_next.position = position;
    if (length > expected_length || length > bcedit_pkg::LenW'(bcedit_pkg::MaxBases)) begin
      item_next.status = bcedit_pkg::STATUS_TOO_LONG;
    end else if (position >= length) begin
      item_next.status = bcedit_pkg::STATUS_BAD_POS;
    end else begin
      item_next.status = bcedit_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      slot   <= '0;
    end else if (accept) begin
      loaded <= 1'b1;
      slot   <= '0;
    end else if (loaded) begin
      if (res.last) begin
        loaded <= 1'b0;
      end else begin
        slot <= slot + bcedit_pkg::SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

  bcedit_edit u_edit (
    .item (item),
    .slot (slot),
    .res  (res)
  );

  // Result register: every occupied slot produces exactly one strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= loaded;
    end
  end

  always_ff @(posedge clk) begin
    neighbor  <= res.neighbor;
    edit_kind <= res.kind;
    edit_base <= res.base;
    status    <= res.status;
    last      <= res.last;
  end

endmodule

// ===== rtl/core/bcedit_checker.sv =====
// Port-level checks for barcode_one_edit_neighbors, attached by bind.
// Depends on bcedit_pkg.
module bcedit_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            result_strobe,
  input logic [bcedit_pkg::BarcodeW-1:0] neighbor,
  input logic [1:0]                      status,
  input logic                            last
);

  // Reset leaves no result on the port.
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !result_strobe)
    else $error("result strobed right after reset");

  // An accepted item shows its first result after the item and result registers.
  a_first_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 result_strobe)
    else $error("accepted item produced no result");

  // While busy, the next cycle carries a result that is not the final one.
  a_busy_more: assert property (@(posedge clk) disable iff (rst)
    busy |=> (result_strobe && !last))
    else $error("busy without a following non-final result");

  // A rejected item gives a single, final, zero result.
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && status != bcedit_pkg::STATUS_OK) |-> (last && neighbor == '0))
    else $error("error result not final or not zero");

endmodule

bind barcode_one_edit_neighbors bcedit_checker u_bcedit_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .neighbor      (neighbor),
  .status        (status),
  .last          (last)
);

// ===== tb/sv/tb_barcode_one_edit_neighbors.sv =====
// Self-checking testbench for barcode_one_edit_neighbors: directed and random items
// against a behavioral neighbor predictor, with random start gaps and length limit writes.
// Depends on bcedit_pkg and the barcode_one_edit_neighbors RTL; reads no files.
module tb_barcode_one_edit_neighbors;
  import bcedit_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int TimeoutCycles = 100000;
  // Results follow the transfer via the item and result registers, so a short
  // pause after the last expected result is enough to see any stray strobes.
  localparam int DrainCycles   = 20;
  localparam int IdleWaitLimit = 2000;

  // Bases are visited in the order A, T, C, G. Entry j sits in bits 2j+1:2j.
  localparam logic [7:0] VisitOrder = {BaseG, BaseC, BaseT, BaseA};

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [BarcodeW-1:0] barcode;
  logic [LenW-1:0]     length;
  logic [LenW-1:0]     position;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LenW-1:0]     cfg_data;
  logic                result_strobe;
  logic [BarcodeW-1:0] neighbor;
  logic [1:0]          edit_kind;
  logic [1:0]          edit_base;
  logic [1:0]          status;
  logic                last;

  // Our own copy of the length limit register, updated on every write transfer.
  logic [LenW-1:0] model_expected_length;
  // Neighbors still to come, oldest first.
  result_t         expected_neighbors[$];
  int              error_count;
  // When set, the item sender never pauses between items.
  bit              no_gaps;

  barcode_one_edit_neighbors u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .barcode       (barcode),
    .length        (length),
    .position      (position),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .neighbor      (neighbor),
    .edit_kind     (edit_kind),
    .edit_base     (edit_base),
    .status        (status),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // A hung handshake or a missing result ends up here.
  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Mask over the low n bases; n of MaxBases or more covers the whole barcode.
  function automatic logic [63:0] bases_mask(input int n);
    if (n >= MaxBases) begin
      return '1;
    end
    return (64'd1 << (2 * n)) - 64'd1;
  endfunction

  task automatic add_neighbor(input logic [63:0] nb, input edit_kind_t kind,
                              input logic [1:0] b, input status_t st);
    result_t r;
    r.neighbor = BarcodeW'(nb);
    r.kind     = kind;
    r.base     = b;
    r.status   = st;
    r.last     = 1'b0;
    expected_neighbors.push_back(r);
  endtask

  // Works out every result of one transferred item and queues them in order.
  task automatic predict_neighbors(input logic [BarcodeW-1:0] bc,
                                   input logic [LenW-1:0] len,
                                   input logic [LenW-1:0] pos);
    logic [63:0] x;
    logic [63:0] low;
    logic [63:0] lowm;
    logic [63:0] ins;
    logic [63:0] del;
    logic [1:0]  cur;
    logic [1:0]  b;
    int          l;
    int          p;
    l = len;
    p = pos;
    // The length check wins over the position check when both fail.
    if (len > model_expected_length || l > MaxBases) begin
      add_neighbor('0, EDIT_SUB, BaseA, STATUS_TOO_LONG);
    end else if (pos >= len) begin
      add_neighbor('0, EDIT_SUB, BaseA, STATUS_BAD_POS);
    end else begin
      // Bits above the barcode length are dropped before any edit.
      x    = 64'(bc) & bases_mask(l);
      cur  = x[2 * p +: 2];
      lowm = bases_mask(p);
      low  = x & lowm;
      // Substitutions skip the base that is already there.
      for (int j = 0; j < 4; j++) begin
        b = VisitOrder[2 * j +: 2];
        if (b != cur) begin
          add_neighbor((x & ~(64'd3 << (2 * p))) | (64'(b) << (2 * p)), EDIT_SUB, b,
                       STATUS_OK);
        end
      end
      // An insertion pushes the tail up and loses the final base; a deletion
      // pulls the tail down and appends the base at the end.
      if (p != l - 1) begin
        for (int j = 0; j < 4; j++) begin
          b   = VisitOrder[2 * j +: 2];
          ins = (low | ((x & ~lowm) << 2) | (64'(b) << (2 * p))) & bases_mask(l);
          del = ((low | ((x >> 2) & ~lowm)) & bases_mask(l - 1)) | (64'(b) << (2 * (l - 1)));
          add_neighbor(ins, EDIT_INS, b, STATUS_OK);
          add_neighbor(del, EDIT_DEL, b, STATUS_OK);
        end
      end
    end
    expected_neighbors[expected_neighbors.size() - 1].last = 1'b1;
  endtask

  // Sends one item. A random gap goes first unless gaps are off. Start is left
  // high afterwards so that back-to-back items keep it high without a dip.
  task automatic send_item(input logic [BarcodeW-1:0] bc, input logic [LenW-1:0] len,
                           input logic [LenW-1:0] pos);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    barcode  <= bc;
    length   <= len;
    position <= pos;
    // busy is read before the edge updates it, so this is the transfer edge.
    do @(posedge clk); while (busy);
    predict_neighbors(bc, len, pos);
  endtask

  // Lowers start and waits until every queued neighbor has arrived, plus a
  // short pause. Anything still queued after the limit is a failure.
  task automatic wait_idle();
    int waited;
    start  <= 1'b0;
    waited = 0;
    while (expected_neighbors.size() != 0 && waited < IdleWaitLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (expected_neighbors.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_neighbors.size()));
      expected_neighbors.delete();
    end
  endtask

  // Length limit writes happen only with the block idle.
  task automatic write_expected_length(input logic [LenW-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_expected_length = value;
  endtask

  // Runs with the limit as reset left it: base extremes, first, middle and
  // last positions, stray bits above the length, and both kinds of rejection.
  task automatic test_reset_length_items();
    no_gaps = 1'b0;
    send_item(40'h00_0000_0000, 5'd16, 5'd0);
    send_item(40'hFF_FFFF_FFFF, 5'd16, 5'd15);
    send_item(40'h12_3456_789A, 5'd16, 5'd7);
    send_item(40'hAA_AAAA_AAAA, 5'd16, 5'd8);
    send_item(40'h55_5555_5555, 5'd12, 5'd3);
    send_item(40'hFF_FFFF_FFFF, 5'd5, 5'd2);
    send_item(40'hFF_FFFF_FFFE, 5'd1, 5'd0);
    send_item(40'h0F_0F0F_0F0F, 5'd17, 5'd0);
    send_item(40'h3C_3C3C_3C3C, 5'd5, 5'd5);
    send_item(40'h3C_3C3C_3C3C, 5'd5, 5'd31);
    send_item(40'hC3_C3C3_C3C3, 5'd0, 5'd0);
    send_item(40'h96_9696_9696, 5'd20, 5'd25);
    send_item(40'h69_6969_6969, 5'd31, 5'd3);
  endtask

  // Moves the limit to its extremes and to values outside its normal range.
  task automatic test_length_limit_extremes();
    write_expected_length(5'd20);
    send_item(40'hFF_FFFF_FFFF, 5'd20, 5'd0);
    send_item(40'hE4_E4E4_E4E4, 5'd20, 5'd19);
    send_item(40'h1B_1B1B_1B1B, 5'd20, 5'd10);
    send_item(40'h1B_1B1B_1B1B, 5'd21, 5'd0);
    write_expected_length(5'd1);
    send_item(40'h00_0000_0003, 5'd1, 5'd0);
    send_item(40'h00_0000_0002, 5'd2, 5'd0);
    send_item(40'h00_0000_0001, 5'd1, 5'd1);
    // A limit of zero rejects every nonzero length as too long, and a zero
    // length as a position error.
    write_expected_length(5'd0);
    send_item(40'h00_0000_0001, 5'd1, 5'd0);
    send_item(40'h00_0000_0001, 5'd0, 5'd0);
    // Above the datapath size the block still rejects lengths over twenty.
    write_expected_length(5'd31);
    send_item(40'hA5_A5A5_A5A5, 5'd20, 5'd5);
    send_item(40'hA5_A5A5_A5A5, 5'd21, 5'd5);
    send_item(40'h5A_5A5A_5A5A, 5'd31, 5'd30);
  endtask

  // Random items under one limit setting. Most are well formed with random
  // bases, biased toward the first and last positions; the rest are noise
  // over the whole field ranges. Gap mode changes every so often so that
  // some stretches run with no pauses at all.
  task automatic test_random_items(input int count, input logic [LenW-1:0] limit);
    logic [BarcodeW-1:0] bc;
    logic [LenW-1:0]     len;
    logic [LenW-1:0]     pos;
    int                  max_len;
    write_expected_length(limit);
    max_len = (limit > MaxBases) ? MaxBases : limit;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      bc = BarcodeW'({$urandom(), $urandom()});
      if (max_len == 0 || $urandom_range(0, 4) == 0) begin
        len = LenW'($urandom_range(0, 31));
        pos = LenW'($urandom_range(0, 31));
      end else begin
        len = LenW'($urandom_range(1, max_len));
        case ($urandom_range(0, 3))
          0: begin
            pos = len - 5'd1;
          end
          1: begin
            pos = '0;
          end
          default: begin
            pos = LenW'($urandom_range(0, len - 1));
          end
        endcase
      end
      send_item(bc, len, pos);
    end
  endtask

  // Every strobed result transfers at the edge that ends its cycle; outputs
  // are read here before that edge changes them.
  always @(posedge clk) begin : check_results
    result_t exp_r;
    if (!rst && result_strobe) begin
      if (expected_neighbors.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: nb=%h kind=%0d base=%0d",
                                  neighbor, edit_kind, edit_base));
      end else begin
        exp_r = expected_neighbors.pop_front();
        if (neighbor !== exp_r.neighbor || edit_kind !== exp_r.kind ||
            edit_base !== exp_r.base || status !== exp_r.status || last !== exp_r.last) begin
          report_mismatch({
            $sformatf("got nb=%h kind=%0d base=%0d st=%0d last=%0b",
                      neighbor, edit_kind, edit_base, status, last),
            $sformatf(", want nb=%h kind=%0d base=%0d st=%0d last=%0b",
                      exp_r.neighbor, exp_r.kind, exp_r.base, exp_r.status, exp_r.last)});
        end
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    barcode   <= '0;
    length    <= '0;
    position  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    error_count = 0;
    no_gaps     = 1'b0;
    model_expected_length = ExpectedLengthReset;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_length_items();
    test_length_limit_extremes();
    test_random_items(60, 5'd16);
    test_random_items(80, 5'd20);
    test_random_items(20, 5'd1);
    test_random_items(50, 5'd9);
    test_random_items(60, LenW'($urandom_range(1, 20)));
    test_random_items(40, 5'd31);
    test_random_items(20, 5'd0);

    wait_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
